### rtl/kmt_pkg.sv
`timescale 1ns / 1ps

package kmt_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int RND_W           = 16;
	localparam int STEP_W          = $clog2(RND_W);
	localparam int CNT_OUT_W       = 7;

	localparam logic [1:0] REQ_UPSERT = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_SELECT = 2'd2;
	localparam logic [1:0] REQ_SORT   = 2'd3;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  node;
		logic [7:0]  leaf;
		logic [31:0] utility;
	} kmt_rec_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [7:0]       in_id;
		logic [7:0]       in_node;
		logic [7:0]       in_leaf;
		logic [31:0]      in_utility;
		logic [RND_W-1:0] random_value;
	} kmt_req_t;

	typedef struct packed {
		logic                 was_inserted;
		logic                 table_full;
		logic                 found_valid;
		logic [7:0]           out_id;
		logic [7:0]           out_node;
		logic [7:0]           out_leaf;
		logic [31:0]          out_utility;
		logic [CNT_OUT_W-1:0] entry_count;
	} kmt_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPS_RD,
		ST_UPS_CHK,
		ST_DIV,
		ST_SEL_RD,
		ST_SEL_WAIT,
		ST_SORT_LD,
		ST_SORT_LDW,
		ST_SORT_RD,
		ST_SORT_CHK,
		ST_SORT_WB,
		ST_DONE
	} kmt_state_t;

endpackage

### rtl/kmt_req_if.sv
`timescale 1ns / 1ps

interface kmt_req_if import kmt_pkg::*; ();
	logic     valid;
	logic     ready;
	kmt_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/kmt_rsp_if.sv
`timescale 1ns / 1ps

interface kmt_rsp_if import kmt_pkg::*; ();
	logic     valid;
	logic     ready;
	kmt_rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/kmt_ram.sv
`timescale 1ns / 1ps

module kmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/keyed_message_table_unit.sv
`timescale 1ns / 1ps

// Keyed record table with upsert, clear, random select and descending sort by id.
//
// Channels: req (sink) carries one request item, rsp (source) returns exactly one
// result item per request, both valid/ready; an item moves when valid and ready are high.
// The records live in one single-port-read RAM; every record access is one read
// issued and checked in the cycle after; from the accepting cycle on, each request
// works as follows up to the result being loaded:
//   clear          : zeroes the count only
//   upsert         : searches from slot 0, overwrites the record on an id hit, else
//                    appends, or drops the item when the table is full
//   select         : a bit-serial remainder of the random value by the count, then
//                    a read of that slot; no read when the table is empty
//   sort           : selection exchange, one compare a step; skipped below two records
// req.ready is high only while the sequencer is idle; one request is worked at a time.
// The result sits in an output register, so a new request is taken while rsp waits;
// if rsp is stalled when the next result finishes, the sequencer holds it until the
// register frees up.
// Reset empties the table (count to zero) and drops any pending result; the record
// RAM is not cleared, since only records below the count are ever read.
module keyed_message_table_unit import kmt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kmt_req_if.sink    req,
	kmt_rsp_if.source  rsp
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);

	kmt_state_t state_q, state_d;

	kmt_req_t         req_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	kmt_rec_t         cur_q;
	logic [CW-1:0]    rem_q;
	logic [RND_W-1:0] dvd_q;
	logic [STEP_W-1:0] step_q;
	logic             ins_q;
	logic             full_q;
	logic             fv_q;
	kmt_rec_t         sel_q;
	kmt_rsp_t         out_q;
	logic             out_valid_q;

	// RAM port
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	kmt_rec_t      ram_wdata;
	logic [IW-1:0] ram_raddr;
	kmt_rec_t      ram_rdata;

	// Shared compare / subtract helpers
	logic [CW:0] trial;
	logic [CW:0] rem_nx;
	logic        trial_ge;
	logic        id_hit;
	logic        sort_swap;
	logic        tbl_full;
	logic        i_last;
	logic        out_free;
	kmt_rec_t    new_rec;

	kmt_ram #(
		.WIDTH($bits(kmt_rec_t)),
		.DEPTH(MAX_ENTRIES)
	) u_kmt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Restoring remainder step: shift in one dividend bit, subtract the count if it fits.
	assign trial     = {rem_q, dvd_q[RND_W-1]};
	assign trial_ge  = trial >= {1'b0, cnt_q};
	assign rem_nx    = trial_ge ? (trial - {1'b0, cnt_q}) : trial;

	assign id_hit    = ram_rdata.id == req_q.in_id;
	assign sort_swap = cur_q.id < ram_rdata.id;
	assign tbl_full  = cnt_q == CW'(MAX_ENTRIES);
	// Outer sort loop ends when the next pass would have no partner left.
	assign i_last    = ({1'b0, i_q} + (CW + 1)'(2)) >= {1'b0, cnt_q};
	assign out_free  = !out_valid_q || rsp.ready;

	assign new_rec.id      = req_q.in_id;
	assign new_rec.node    = req_q.in_node;
	assign new_rec.leaf    = req_q.in_leaf;
	assign new_rec.utility = req_q.in_utility;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					unique case (req.data.req_type)
						REQ_UPSERT: state_d = ST_UPS_RD;
						REQ_CLEAR:  state_d = ST_DONE;
						REQ_SELECT: state_d = (cnt_q == '0) ? ST_DONE : ST_DIV;
						REQ_SORT:   state_d = (cnt_q < CW'(2)) ? ST_DONE : ST_SORT_LD;
					endcase
				end
			end
			ST_UPS_RD:   state_d = (i_q == cnt_q) ? ST_DONE : ST_UPS_CHK;
			ST_UPS_CHK:  state_d = id_hit ? ST_DONE : ST_UPS_RD;
			ST_DIV:      state_d = (step_q == '1) ? ST_SEL_RD : ST_DIV;
			ST_SEL_RD:   state_d = ST_SEL_WAIT;
			ST_SEL_WAIT: state_d = ST_DONE;
			ST_SORT_LD:  state_d = ST_SORT_LDW;
			ST_SORT_LDW: state_d = ST_SORT_RD;
			ST_SORT_RD:  state_d = (j_q == cnt_q) ? ST_SORT_WB : ST_SORT_CHK;
			ST_SORT_CHK: state_d = ST_SORT_RD;
			ST_SORT_WB:  state_d = i_last ? ST_DONE : ST_SORT_LD;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and RAM controls
	always_comb begin
		req.ready = state_q == ST_IDLE;
		ram_we    = 1'b0;
		ram_waddr = i_q[IW-1:0];
		ram_wdata = cur_q;
		ram_raddr = i_q[IW-1:0];
		unique case (state_q)
			ST_UPS_RD: begin
				// search exhausted: append unless the table is full
				if (i_q == cnt_q && !tbl_full) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[IW-1:0];
					ram_wdata = new_rec;
				end
			end
			ST_UPS_CHK: begin
				if (id_hit) begin
					ram_we    = 1'b1;
					ram_wdata = new_rec;
				end
			end
			ST_SEL_RD: ram_raddr = rem_q[IW-1:0];
			ST_SORT_RD: ram_raddr = j_q[IW-1:0];
			ST_SORT_CHK: begin
				// hand the held record down to slot j, keep the larger one
				if (sort_swap) begin
					ram_we    = 1'b1;
					ram_waddr = j_q[IW-1:0];
				end
			end
			ST_SORT_WB: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && req.valid && req.data.req_type == REQ_CLEAR) begin
				cnt_q <= '0;
			end else if (state_q == ST_UPS_RD && i_q == cnt_q && !tbl_full) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.was_inserted <= ins_q;
			out_q.table_full   <= full_q;
			out_q.found_valid  <= fv_q;
			out_q.out_id       <= sel_q.id;
			out_q.out_node     <= sel_q.node;
			out_q.out_leaf     <= sel_q.leaf;
			out_q.out_utility  <= sel_q.utility;
			out_q.entry_count  <= CNT_OUT_W'(cnt_q);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					req_q  <= req.data;
					i_q    <= '0;
					ins_q  <= 1'b0;
					full_q <= 1'b0;
					fv_q   <= 1'b0;
					sel_q  <= '0;
					dvd_q  <= req.data.random_value;
					rem_q  <= '0;
					step_q <= '0;
				end
			end
			ST_UPS_RD: begin
				if (i_q == cnt_q) begin
					full_q <= tbl_full;
					ins_q  <= !tbl_full;
				end
			end
			ST_UPS_CHK: begin
				if (!id_hit) begin
					i_q <= i_q + CW'(1);
				end
			end
			ST_DIV: begin
				rem_q  <= rem_nx[CW-1:0];
				dvd_q  <= {dvd_q[RND_W-2:0], 1'b0};
				step_q <= step_q + STEP_W'(1);
			end
			ST_SEL_WAIT: begin
				fv_q  <= 1'b1;
				sel_q <= ram_rdata;
			end
			ST_SORT_LD:  j_q <= i_q + CW'(1);
			ST_SORT_LDW: cur_q <= ram_rdata;
			ST_SORT_CHK: begin
				if (sort_swap) begin
					cur_q <= ram_rdata;
				end
				j_q <= j_q + CW'(1);
			end
			ST_SORT_WB: i_q <= i_q + CW'(1);
			default: ;
		endcase
	end

endmodule

### rtl/kmt_chk.sv
`timescale 1ns / 1ps

module kmt_chk import kmt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input kmt_rsp_t rsp_data
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one request at a time: busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp_data.was_inserted, rsp_data.table_full,
			rsp_data.found_valid}) <= 1)
		else $error("conflicting result flags");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.table_full |-> rsp_data.entry_count == CNT_OUT_W'(MAX_ENTRIES))
		else $error("table full reported below capacity");

endmodule

bind keyed_message_table_unit kmt_chk #(
	.MAX_ENTRIES(MAX_ENTRIES)
) u_kmt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);
